### hw/rtl/ws2812enc_pkg.sv
// Shared types, constants and helpers of the WS2812 pixel bit encoder.
package ws2812enc_pkg;

    localparam int SYMBOLS_PER_PIXEL = 24;
    localparam int SYM_CNT_W         = 5;
    localparam int CFG_IDX_W         = 3;

    localparam logic [7:0] RST_BRIGHTNESS = 8'd255;
    localparam logic [7:0] RST_T0H_TICKS  = 8'd4;
    localparam logic [7:0] RST_T0L_TICKS  = 8'd8;
    localparam logic [7:0] RST_T1H_TICKS  = 8'd8;
    localparam logic [7:0] RST_T1L_TICKS  = 8'd4;

    localparam logic [SYM_CNT_W-1:0] LAST_SYM_IDX = SYM_CNT_W'(SYMBOLS_PER_PIXEL - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BRIGHTNESS = 3'd0,
        CFG_ZERO_HIGH  = 3'd1,
        CFG_ZERO_LOW   = 3'd2,
        CFG_ONE_HIGH   = 3'd3,
        CFG_ONE_LOW    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] high_ticks;
        logic [7:0] low_ticks;
        logic       last_symbol;
    } t_symbol;

    // Scaled pixel in line order: green first, MSB first.
    typedef struct packed {
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] blue;
    } t_scaled;

    typedef struct packed {
        logic [7:0] zero_high;
        logic [7:0] zero_low;
        logic [7:0] one_high;
        logic [7:0] one_low;
    } t_timing;

    // floor(p / 255) for p up to 255*255, without a divider.
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
        return s[15:8];
    endfunction

endpackage

### hw/rtl/ws2812_pixel_bit_encoder.sv
// WS2812 pixel bit encoder: one RGB request in, 24 timed GRB line symbols out.
// The first symbol of a pixel passes the product register, the queue write, the shifter load
//   and the symbol register before it shows on o_out_valid; later ones 1 per cycle unless stalled.
// Throughput: one symbol per cycle while i_out_stall is low, set by the back end shifter;
//   the front end takes a request per cycle until the pixel queue fills.
// Reset: synchronous active low; clears the queue and control, loads register defaults.
module ws2812_pixel_bit_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // pixel request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  ws2812enc_pkg::t_pixel_in             i_in_data,
    // line symbol channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output ws2812enc_pkg::t_symbol               o_out_data,
    // register write channel
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [ws2812enc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);
    import ws2812enc_pkg::*;

    logic    [7:0] r_brightness;
    t_timing       r_timing;
    logic          cfg_we;

    logic          q_push;
    t_scaled       q_push_data;
    logic          q_pop;
    t_scaled       q_head;
    logic          q_full;
    logic          q_empty;

    // Registers take a write in any cycle; writes beyond the register list drop.
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness       <= RST_BRIGHTNESS;
            r_timing.zero_high <= RST_T0H_TICKS;
            r_timing.zero_low  <= RST_T0L_TICKS;
            r_timing.one_high  <= RST_T1H_TICKS;
            r_timing.one_low   <= RST_T1L_TICKS;
        end else if (cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_BRIGHTNESS: r_brightness       <= i_cfg_data;
                CFG_ZERO_HIGH:  r_timing.zero_high <= i_cfg_data;
                CFG_ZERO_LOW:   r_timing.zero_low  <= i_cfg_data;
                CFG_ONE_HIGH:   r_timing.one_high  <= i_cfg_data;
                CFG_ONE_LOW:    r_timing.one_low   <= i_cfg_data;
                default:        r_brightness       <= r_brightness;
            endcase
        end
    end

    // Front end: scale each channel by brightness, truncated, and hand the
    // pixel to the queue in line order (green, red, blue).
    ws2812enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_brightness (r_brightness),
        .o_push       (q_push),
        .o_push_data  (q_push_data),
        .i_full       (q_full)
    );

    // Queue decouples the front, which takes a pixel per cycle while the queue has room, from the slower back.
    ws2812enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .i_pop       (q_pop),
        .o_head      (q_head),
        .o_full      (q_full),
        .o_empty     (q_empty)
    );

    // Back end: emit MSB first, one symbol per cycle unless the output stalls; pop the next pixel
    // in the same cycle the last symbol of the current one is registered.
    ws2812enc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .i_timing    (r_timing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // Front end only stalls requests when a scaled pixel cannot enter the queue.
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> q_full)
        else $error("request stalled while queue has room");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("push into full pixel queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty pixel queue");

endmodule

### hw/rtl/ws2812enc_front.sv
// Front end: accepts pixels, scales them by brightness, pushes them to the queue.
module ws2812enc_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  ws2812enc_pkg::t_pixel_in i_in_data,
    input  logic [7:0]               i_brightness,
    output logic                     o_push,
    output ws2812enc_pkg::t_scaled   o_push_data,
    input  logic                     i_full
);
    import ws2812enc_pkg::*;

    logic        r_p_valid;
    logic [15:0] r_prod_r;
    logic [15:0] r_prod_g;
    logic [15:0] r_prod_b;
    logic        accept;

    assign o_in_stall = r_p_valid & i_full;
    assign accept     = i_in_valid & ~o_in_stall;
    assign o_push     = r_p_valid & ~i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (accept) begin
            r_p_valid <= 1'b1;
        end else if (o_push) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod_r <= 16'(i_in_data.red   * i_brightness);
            r_prod_g <= 16'(i_in_data.green * i_brightness);
            r_prod_b <= 16'(i_in_data.blue  * i_brightness);
        end
    end

    always_comb begin
        o_push_data.green = div255(r_prod_g);
        o_push_data.red   = div255(r_prod_r);
        o_push_data.blue  = div255(r_prod_b);
    end

endmodule

### hw/rtl/ws2812enc_queue.sv
// Short pixel queue between the scaling front end and the symbol back end.
module ws2812enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  ws2812enc_pkg::t_scaled i_push_data,
    input  logic                   i_pop,
    output ws2812enc_pkg::t_scaled o_head,
    output logic                   o_full,
    output logic                   o_empty
);
    import ws2812enc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_scaled         r_slot [DEPTH];
    logic [AW-1:0]   r_wr_ptr;
    logic [AW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   n_wr_ptr;
    logic [AW-1:0]   n_rd_ptr;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slot[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

### hw/rtl/ws2812enc_back.sv
// Back end: shifts a scaled pixel out as 24 timed line symbols.
module ws2812enc_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_empty,
    input  ws2812enc_pkg::t_scaled i_head,
    output logic                   o_pop,
    input  ws2812enc_pkg::t_timing i_timing,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output ws2812enc_pkg::t_symbol o_out_data
);
    import ws2812enc_pkg::*;

    logic [23:0]          r_bits;
    logic [SYM_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_out_valid;
    t_symbol              r_out_data;
    logic                 adv;
    logic                 last;
    t_symbol              n_sym;

    assign adv   = r_busy & (~r_out_valid | ~i_out_stall);
    assign last  = (r_cnt == LAST_SYM_IDX);
    assign o_pop = ~i_empty & (~r_busy | (adv & last));

    always_comb begin
        n_sym.high_ticks  = r_bits[23] ? i_timing.one_high : i_timing.zero_high;
        n_sym.low_ticks   = r_bits[23] ? i_timing.one_low  : i_timing.zero_low;
        n_sym.last_symbol = last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (adv) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= i_head;
        end else if (adv) begin
            r_bits <= {r_bits[22:0], 1'b0};
        end
        if (adv) begin
            r_out_data <= n_sym;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### verif/tb_ws2812_pixel_bit_encoder.sv
// Self-checking testbench for the WS2812 pixel bit encoder, with its own symbol predictor.
`timescale 1ns / 1ps

module tb_ws2812_pixel_bit_encoder;
    import ws2812enc_pkg::*;

    localparam int IDLE_PCT    = 14;    // chance in a hundred that a side idles
    localparam int WATCHDOG    = 5000;  // cycles with no handshake before giving up
    localparam int MAX_PRINTED = 100;   // mismatch lines shown before going quiet
    localparam int FULL_SCALE  = 255;
    localparam int PHASE_ITEMS = 27;
    localparam int REG_COUNT   = 5;     // indexes at and above this are not registers
    localparam int END_CYCLES  = 20;

    logic                 i_clk;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_pixel_in            i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_symbol              o_out_data;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [7:0]           i_cfg_data  = '0;

    // Pixels waiting to be presented, and line symbols waiting to come out.
    t_pixel_in pixel_queue[$];
    t_symbol   symbol_queue[$];

    // Shadow copy of the block's registers.
    logic [7:0] brightness_reg;
    t_timing    timing_reg;

    bit steady_run  = 1'b0;   // no idling on either side while set
    int mismatches  = 0;
    int idle_cycles = 0;
    int symbols_out = 0;

    ws2812_pixel_bit_encoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Scale one channel by the global brightness, truncating.
    function automatic logic [7:0] scale_channel(logic [7:0] level);
        return 8'((int'(level) * int'(brightness_reg)) / FULL_SCALE);
    endfunction

    // Queue the 24 symbols of one pixel: GRB order, each byte MSB first.
    function automatic void predict_symbols(t_pixel_in px);
        t_scaled    line;
        logic [23:0] bits;
        t_symbol    sym;
        line.green = scale_channel(px.green);
        line.red   = scale_channel(px.red);
        line.blue  = scale_channel(px.blue);
        bits = line;
        for (int n = 0; n < SYMBOLS_PER_PIXEL; n++) begin
            if (bits[SYMBOLS_PER_PIXEL - 1 - n]) begin
                sym.high_ticks = timing_reg.one_high;
                sym.low_ticks  = timing_reg.one_low;
            end else begin
                sym.high_ticks = timing_reg.zero_high;
                sym.low_ticks  = timing_reg.zero_low;
            end
            sym.last_symbol = (n == SYMBOLS_PER_PIXEL - 1);
            symbol_queue.push_back(sym);
        end
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= MAX_PRINTED) begin
            $display("[%0t] %s", $realtime, what);
        end
    endtask

    // Driver: present the next pixel once the previous request is taken; stall at random.
    always @(posedge i_clk) begin
        if (!i_in_valid || !o_in_stall) begin
            if (pixel_queue.size() != 0 && (steady_run || $urandom_range(99) >= IDLE_PCT)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= pixel_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !steady_run && ($urandom_range(99) < IDLE_PCT);
    end

    // Monitor: predict on each accepted request, check each accepted symbol, watch for hangs.
    always @(posedge i_clk) begin
        t_symbol want;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_symbols(i_in_data);
                moved = 1'b1;
            end
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (symbol_queue.size() == 0) begin
                    report_mismatch($sformatf("symbol %0d with none expected: high %0d low %0d last %0b",
                        symbols_out, o_out_data.high_ticks, o_out_data.low_ticks,
                        o_out_data.last_symbol));
                end else begin
                    want = symbol_queue.pop_front();
                    if (o_out_data.high_ticks !== want.high_ticks
                            || o_out_data.low_ticks !== want.low_ticks
                            || o_out_data.last_symbol !== want.last_symbol) begin
                        report_mismatch($sformatf(
                            "symbol %0d: high %0d/%0d low %0d/%0d last %0b/%0b (got/want)",
                            symbols_out, o_out_data.high_ticks, want.high_ticks,
                            o_out_data.low_ticks, want.low_ticks,
                            o_out_data.last_symbol, want.last_symbol));
                    end
                end
                symbols_out++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG) begin
            $display("ws2812_pixel_bit_encoder: mismatch");
            $finish;
        end
    end

    // Write one register and mirror it in the shadow copy; indexes past the list are ignored.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        case (t_cfg_idx'(idx))
            CFG_BRIGHTNESS: brightness_reg       = value;
            CFG_ZERO_HIGH:  timing_reg.zero_high = value;
            CFG_ZERO_LOW:   timing_reg.zero_low  = value;
            CFG_ONE_HIGH:   timing_reg.one_high  = value;
            CFG_ONE_LOW:    timing_reg.one_low   = value;
            default: ;
        endcase
    endtask

    task automatic write_timing(logic [7:0] zh, logic [7:0] zl, logic [7:0] oh, logic [7:0] ol);
        write_reg(CFG_ZERO_HIGH, zh);
        write_reg(CFG_ZERO_LOW, zl);
        write_reg(CFG_ONE_HIGH, oh);
        write_reg(CFG_ONE_LOW, ol);
    endtask

    // Hold until every pixel is taken and every symbol has come out.
    task automatic drain;
        do @(negedge i_clk);
        while (pixel_queue.size() != 0 || i_in_valid || symbol_queue.size() != 0);
    endtask

    // Lean toward black and full scale, else any level.
    function automatic logic [7:0] random_level();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_pixel_in make_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        t_pixel_in px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        return px;
    endfunction

    // Queue a batch of random pixels on top of anything already queued, then drain.
    task automatic run_random(int count);
        @(negedge i_clk);
        repeat (count) begin
            pixel_queue.push_back(make_pixel(random_level(), random_level(), random_level()));
        end
        drain();
    endtask

    initial begin
        brightness_reg = RST_BRIGHTNESS;
        timing_reg     = {RST_T0H_TICKS, RST_T0L_TICKS, RST_T1H_TICKS, RST_T1L_TICKS};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: black, white, each channel alone, and walking bit patterns.
        @(negedge i_clk);
        pixel_queue.push_back(make_pixel(8'h00, 8'h00, 8'h00));
        pixel_queue.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF));
        pixel_queue.push_back(make_pixel(8'hFF, 8'h00, 8'h00));
        pixel_queue.push_back(make_pixel(8'h00, 8'hFF, 8'h00));
        pixel_queue.push_back(make_pixel(8'h00, 8'h00, 8'hFF));
        pixel_queue.push_back(make_pixel(8'h80, 8'h40, 8'h01));
        pixel_queue.push_back(make_pixel(8'h55, 8'hAA, 8'h0F));
        pixel_queue.push_back(make_pixel(8'h01, 8'h80, 8'hFE));
        drain();

        // Zero brightness turns every bit into a zero; timings at their extremes.
        write_reg(CFG_BRIGHTNESS, 8'd0);
        write_timing(8'd1, 8'd255, 8'd255, 8'd1);
        @(negedge i_clk);
        pixel_queue.push_back(make_pixel(8'hFF, 8'hFF, 8'hFF));
        pixel_queue.push_back(make_pixel(8'h80, 8'h7F, 8'h01));
        run_random(PHASE_ITEMS);

        // Timing registers written as zero pass straight through; unused indexes do nothing.
        write_reg(CFG_BRIGHTNESS, 8'd1);
        write_timing(8'd0, 8'd0, 8'd0, 8'd0);
        for (int k = REG_COUNT; k < (1 << CFG_IDX_W); k++) begin
            write_reg(k[CFG_IDX_W-1:0], 8'($urandom));
        end
        @(negedge i_clk);
        pixel_queue.push_back(make_pixel(8'hFF, 8'hFE, 8'h00));
        run_random(PHASE_ITEMS);

        // Brightness one step below full, opposite timing extremes.
        write_reg(CFG_BRIGHTNESS, 8'd254);
        write_timing(8'd255, 8'd1, 8'd1, 8'd255);
        run_random(PHASE_ITEMS);

        // Full scale back, reset timings, no idling anywhere.
        write_reg(CFG_BRIGHTNESS, 8'd255);
        write_timing(RST_T0H_TICKS, RST_T0L_TICKS, RST_T1H_TICKS, RST_T1L_TICKS);
        steady_run = 1'b1;
        run_random(PHASE_ITEMS);
        steady_run = 1'b0;

        // Random settings for the rest.
        repeat (4) begin
            write_reg(CFG_BRIGHTNESS, 8'($urandom_range(255)));
            write_timing(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                         8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)));
            run_random(PHASE_ITEMS);
        end

        // Let any stray symbol show up before the verdict.
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ws2812_pixel_bit_encoder: match");
        end else begin
            $display("ws2812_pixel_bit_encoder: mismatch");
        end
        $finish;
    end

endmodule
